/* rtl/token_queue_job_dispatcher_unit_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the token queue job dispatcher
// Shorthand for clocked implications with a synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef TOKEN_QUEUE_JOB_DISPATCHER_UNIT_MACROS_SVH
`define TOKEN_QUEUE_JOB_DISPATCHER_UNIT_MACROS_SVH

// Same-cycle implication.
`define TQJD_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("dispatcher assertion failed");

// Next-cycle implication.
`define TQJD_ASSERT_NXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("dispatcher assertion failed");

`endif

/* rtl/tqjd_pkg.sv */
// ----------------------------------------------------------------------------
// tqjd_pkg
// Shared codes, defaults and controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tqjd_pkg;

    localparam int DEF_NUM_SERVERS = 8;
    localparam int DEF_NUM_TYPES   = 8;
    localparam int DEF_RING_DEPTH  = 128;

    localparam logic [1:0] OP_ARRIVE  = 2'd0;
    localparam logic [1:0] OP_DEPART  = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;
    localparam logic [1:0] OP_NONE    = 2'd3;

    localparam logic [2:0] OUT_ASSIGNED  = 3'd0;
    localparam logic [2:0] OUT_LOST      = 3'd1;
    localparam logic [2:0] OUT_DEPARTED  = 3'd2;
    localparam logic [2:0] OUT_IGNORED   = 3'd3;
    localparam logic [2:0] OUT_RESTARTED = 3'd4;

    localparam logic [1:0] CFG_COMPAT      = 2'd0;
    localparam logic [1:0] CFG_TOKEN_CNTS  = 2'd1;
    localparam logic [1:0] CFG_NUM_TYPES   = 2'd2;
    localparam logic [1:0] CFG_NUM_SERVERS = 2'd3;

    typedef struct packed {
        logic accept;
        logic decode;
        logic scan;
        logic shift;
        logic restart;
        logic load;
    } tqjd_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       arr_ok;
        logic       scan_done;
        logic       scan_hit;
        logic       shift_done;
        logic       restart_done;
    } tqjd_status_t;

endpackage

/* rtl/token_queue_job_dispatcher_unit.sv */
// A departure, or an arrival lost at decode, goes from decode to the response state, where
// its result loads once the output is free. An arrival that walks the ring scans from head
// to tail for the server's earliest token and, if found, shifts the tokens ahead of it; the
// ring port walks one entry a cycle. Restart enqueues the token count of each server in use.
// One item is in work at a time; the next is accepted in the cycle after the result is loaded.
// Reset clears control state, assignments, job counts and configuration; ring contents stay.
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// token_queue_job_dispatcher_unit
// Job dispatcher driven by an ordered ring of idle-server tokens.
// ----------------------------------------------------------------------------
module token_queue_job_dispatcher_unit #(
    parameter int NUM_SERVERS = tqjd_pkg::DEF_NUM_SERVERS,
    parameter int NUM_TYPES   = tqjd_pkg::DEF_NUM_TYPES,
    parameter int RING_DEPTH  = tqjd_pkg::DEF_RING_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_op,
    input  logic [2:0]  s_job_type,
    input  logic [2:0]  s_server,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_outcome,
    output logic [2:0]  m_chosen_server,
    output logic [3:0]  m_jobs_at_server,
    output logic [6:0]  m_tokens_queued,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_wdata
);
    import tqjd_pkg::*;

    tqjd_cmd_t    cmd;
    tqjd_status_t status;

    tqjd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    tqjd_datapath #(
        .NUM_SERVERS (NUM_SERVERS),
        .NUM_TYPES   (NUM_TYPES),
        .RING_DEPTH  (RING_DEPTH)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_op             (s_op),
        .s_job_type       (s_job_type),
        .s_server         (s_server),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .cmd              (cmd),
        .status           (status),
        .m_outcome        (m_outcome),
        .m_chosen_server  (m_chosen_server),
        .m_jobs_at_server (m_jobs_at_server),
        .m_tokens_queued  (m_tokens_queued)
    );

endmodule

/* rtl/tqjd_ctrl.sv */
// ----------------------------------------------------------------------------
// tqjd_ctrl
// Sequencer for the dispatcher: accepts an item, steps the datapath through
// its ring walks and hands the result to the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tqjd_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  logic                   m_ready,
    input  tqjd_pkg::tqjd_status_t status,
    output tqjd_pkg::tqjd_cmd_t    cmd
);
    import tqjd_pkg::*;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_DECODE  = 3'd1;
    localparam logic [2:0] ST_SCAN    = 3'd2;
    localparam logic [2:0] ST_SHIFT   = 3'd3;
    localparam logic [2:0] ST_RESTART = 3'd4;
    localparam logic [2:0] ST_RESP    = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                cmd.decode = 1'b1;
                unique case (status.op)
                    OP_ARRIVE:  state_next = status.arr_ok ? ST_SCAN : ST_RESP;
                    OP_DEPART:  state_next = ST_RESP;
                    OP_RESTART: state_next = ST_RESTART;
                    default:    state_next = ST_IDLE;
                endcase
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (status.scan_done) begin
                    state_next = status.scan_hit ? ST_SHIFT : ST_RESP;
                end
            end
            ST_SHIFT: begin
                cmd.shift = 1'b1;
                if (status.shift_done) begin
                    state_next = ST_RESP;
                end
            end
            ST_RESTART: begin
                cmd.restart = 1'b1;
                if (status.restart_done) begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    cmd.load     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

/* rtl/tqjd_datapath.sv */
// ----------------------------------------------------------------------------
// tqjd_datapath
// Token ring memory, pointers, type assignments, job counts, configuration
// registers and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tqjd_datapath #(
    parameter int NUM_SERVERS = tqjd_pkg::DEF_NUM_SERVERS,
    parameter int NUM_TYPES   = tqjd_pkg::DEF_NUM_TYPES,
    parameter int RING_DEPTH  = tqjd_pkg::DEF_RING_DEPTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [1:0]             s_op,
    input  logic [2:0]             s_job_type,
    input  logic [2:0]             s_server,
    input  logic                   cfg_we,
    input  logic [1:0]             cfg_index,
    input  logic [63:0]            cfg_wdata,
    input  tqjd_pkg::tqjd_cmd_t    cmd,
    output tqjd_pkg::tqjd_status_t status,
    output logic [2:0]             m_outcome,
    output logic [2:0]             m_chosen_server,
    output logic [3:0]             m_jobs_at_server,
    output logic [6:0]             m_tokens_queued
);
    import tqjd_pkg::*;

    localparam int PW = $clog2(RING_DEPTH);
    localparam int SW = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
    localparam int TW = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
    localparam logic [PW-1:0] LAST_PTR  = PW'(RING_DEPTH - 1);
    localparam logic [PW:0]   FULL_CNT  = (PW + 1)'(RING_DEPTH - 1);
    localparam logic [PW:0]   DEPTH_EXT = (PW + 1)'(RING_DEPTH);
    localparam logic [3:0]    MAX_SRV   = 4'(NUM_SERVERS);
    localparam logic [3:0]    MAX_TYP   = 4'(NUM_TYPES);

    // Configuration registers.
    logic [63:0] compat_reg;
    logic [31:0] tcnt_reg;
    logic [3:0]  ntypes_reg;
    logic [3:0]  nsrv_reg;

    // Latched item.
    logic [1:0] op_reg, op_next;
    logic [2:0] type_reg, type_next;
    logic [2:0] srv_reg, srv_next;

    // Ring state.
    logic [2:0]    ring_mem [RING_DEPTH];
    logic [2:0]    rd_data_reg;
    logic [PW-1:0] rd_addr;
    logic          mem_we;
    logic [PW-1:0] mem_waddr;
    logic [2:0]    mem_wdata;
    logic [PW-1:0] head_reg, head_next;
    logic [PW-1:0] tail_reg, tail_next;

    logic       asg_valid_reg [NUM_TYPES];
    logic       asg_valid_next [NUM_TYPES];
    logic [2:0] asg_srv_reg [NUM_TYPES];
    logic [2:0] asg_srv_next [NUM_TYPES];
    logic [3:0] jobs_reg [NUM_SERVERS];
    logic [3:0] jobs_next [NUM_SERVERS];

    // Walk state.
    logic [PW-1:0] iss_reg, iss_next;
    logic          pend_reg, pend_next;
    logic [PW-1:0] pend_addr_reg, pend_addr_next;
    logic          hit_reg, hit_next;
    logic [PW-1:0] hit_addr_reg, hit_addr_next;
    logic [2:0]    carry_reg, carry_next;
    logic [2:0]    tgt_reg, tgt_next;
    logic [PW-1:0] shq_reg, shq_next;
    logic          shfirst_reg, shfirst_next;
    logic [3:0]    rs_srv_reg, rs_srv_next;
    logic [3:0]    rs_left_reg, rs_left_next;
    logic [2:0]    rs_cur_reg, rs_cur_next;

    // Pending result.
    logic [2:0] res_outcome_reg, res_outcome_next;
    logic [2:0] res_chosen_reg, res_chosen_next;
    logic       res_jv_reg, res_jv_next;

    logic [3:0]    eff_srv, eff_typ;
    logic [PW-1:0] ring_cnt;
    logic          ring_full;
    logic          arr_ok;
    logic          srv_ok;
    logic          issue;
    logic          clear_all, unasg_en, claim_en;
    logic [2:0]    claim_srv;
    logic [3:0]    rs_cnt;
    logic [8:0]    cnt_wide;

    function automatic logic [PW-1:0] ring_nxt(input logic [PW-1:0] p);
        return (p == LAST_PTR) ? '0 : p + PW'(1);
    endfunction

    function automatic logic [PW-1:0] ring_len(input logic [PW-1:0] h,
                                               input logic [PW-1:0] t);
        logic [PW:0] d;
        d = {1'b0, t} - {1'b0, h};
        if (t < h) begin
            d = d + DEPTH_EXT;
        end
        return d[PW-1:0];
    endfunction

    assign eff_srv   = (nsrv_reg > MAX_SRV) ? MAX_SRV : nsrv_reg;
    assign eff_typ   = (ntypes_reg > MAX_TYP) ? MAX_TYP : ntypes_reg;
    assign ring_cnt  = ring_len(head_reg, tail_reg);
    assign ring_full = ({1'b0, ring_cnt} >= FULL_CNT);
    assign arr_ok    = ({1'b0, type_reg} < eff_typ) && asg_valid_reg[type_reg[TW-1:0]]
                       && ({1'b0, asg_srv_reg[type_reg[TW-1:0]]} < MAX_SRV);
    assign srv_ok    = ({1'b0, srv_reg} < eff_srv);
    assign issue     = (iss_reg != tail_reg);
    assign rs_cnt    = tcnt_reg[{rs_srv_reg[2:0], 2'b00} +: 4];
    assign rd_addr   = cmd.shift ? ring_nxt(shq_reg) : iss_reg;

    assign status.op           = op_reg;
    assign status.arr_ok       = arr_ok;
    assign status.scan_done    = !pend_reg && !issue;
    assign status.scan_hit     = hit_reg;
    assign status.shift_done   = (shq_reg == hit_addr_reg);
    assign status.restart_done = (rs_left_reg == 4'd0) && (rs_srv_reg >= eff_srv);

    always_comb begin
        op_next          = op_reg;
        type_next        = type_reg;
        srv_next         = srv_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        iss_next         = iss_reg;
        pend_next        = pend_reg;
        pend_addr_next   = pend_addr_reg;
        hit_next         = hit_reg;
        hit_addr_next    = hit_addr_reg;
        carry_next       = carry_reg;
        tgt_next         = tgt_reg;
        shq_next         = shq_reg;
        shfirst_next     = shfirst_reg;
        rs_srv_next      = rs_srv_reg;
        rs_left_next     = rs_left_reg;
        rs_cur_next      = rs_cur_reg;
        res_outcome_next = res_outcome_reg;
        res_chosen_next  = res_chosen_reg;
        res_jv_next      = res_jv_reg;
        jobs_next        = jobs_reg;
        mem_we           = 1'b0;
        mem_waddr        = tail_reg;
        mem_wdata        = srv_reg;
        clear_all        = 1'b0;
        unasg_en         = 1'b0;
        claim_en         = 1'b0;
        claim_srv        = srv_reg;

        if (cmd.accept) begin
            op_next   = s_op;
            type_next = s_job_type;
            srv_next  = s_server;
        end

        if (cmd.decode) begin
            case (op_reg)
                OP_ARRIVE: begin
                    res_outcome_next = OUT_LOST;
                    res_chosen_next  = 3'd0;
                    res_jv_next      = 1'b0;
                    tgt_next         = asg_srv_reg[type_reg[TW-1:0]];
                    iss_next         = head_reg;
                    pend_next        = 1'b0;
                    hit_next         = 1'b0;
                    shq_next         = head_reg;
                    shfirst_next     = 1'b1;
                end
                OP_DEPART: begin
                    res_outcome_next = OUT_IGNORED;
                    res_chosen_next  = srv_reg;
                    res_jv_next      = srv_ok;
                    if (srv_ok && (jobs_reg[srv_reg[SW-1:0]] != 4'd0)) begin
                        jobs_next[srv_reg[SW-1:0]] = jobs_reg[srv_reg[SW-1:0]] - 4'd1;
                        res_outcome_next = OUT_DEPARTED;
                        if (!ring_full) begin
                            mem_we    = 1'b1;
                            tail_next = ring_nxt(tail_reg);
                            claim_en  = 1'b1;
                        end
                    end
                end
                OP_RESTART: begin
                    res_outcome_next = OUT_RESTARTED;
                    res_chosen_next  = 3'd0;
                    res_jv_next      = 1'b0;
                    head_next        = '0;
                    tail_next        = '0;
                    clear_all        = 1'b1;
                    rs_srv_next      = 4'd0;
                    rs_left_next     = 4'd0;
                    for (int i = 0; i < NUM_SERVERS; i++) begin
                        jobs_next[i] = 4'd0;
                    end
                end
                default: ;
            endcase
        end

        // Walk from head to tail: find the server's earliest token, then let
        // every token behind it reclaim the freed types.
        if (cmd.scan) begin
            pend_next      = issue;
            pend_addr_next = iss_reg;
            if (issue) begin
                iss_next = ring_nxt(iss_reg);
            end
            if (pend_reg) begin
                if (pend_addr_reg == head_reg) begin
                    carry_next = rd_data_reg;
                end
                if (!hit_reg) begin
                    if (rd_data_reg == tgt_reg) begin
                        hit_next      = 1'b1;
                        hit_addr_next = pend_addr_reg;
                        unasg_en      = 1'b1;
                    end
                end else begin
                    claim_en  = 1'b1;
                    claim_srv = rd_data_reg;
                end
            end
        end

        // Close the gap: tokens ahead of the removed one move back one slot.
        if (cmd.shift) begin
            if (shq_reg == hit_addr_reg) begin
                head_next = ring_nxt(head_reg);
                if (jobs_reg[tgt_reg[SW-1:0]] != 4'd15) begin
                    jobs_next[tgt_reg[SW-1:0]] = jobs_reg[tgt_reg[SW-1:0]] + 4'd1;
                end
                res_outcome_next = OUT_ASSIGNED;
                res_chosen_next  = tgt_reg;
                res_jv_next      = 1'b1;
            end else begin
                mem_we       = 1'b1;
                mem_waddr    = ring_nxt(shq_reg);
                mem_wdata    = shfirst_reg ? carry_reg : rd_data_reg;
                shq_next     = ring_nxt(shq_reg);
                shfirst_next = 1'b0;
            end
        end

        if (cmd.restart) begin
            if (rs_left_reg == 4'd0) begin
                if (rs_srv_reg < eff_srv) begin
                    rs_left_next = rs_cnt;
                    rs_cur_next  = rs_srv_reg[2:0];
                    rs_srv_next  = rs_srv_reg + 4'd1;
                    if (rs_cnt != 4'd0) begin
                        claim_en  = 1'b1;
                        claim_srv = rs_srv_reg[2:0];
                    end
                end
            end else begin
                rs_left_next = rs_left_reg - 4'd1;
                if (!ring_full) begin
                    mem_we    = 1'b1;
                    mem_wdata = rs_cur_reg;
                    tail_next = ring_nxt(tail_reg);
                end
            end
        end

        for (int k = 0; k < NUM_TYPES; k++) begin
            asg_valid_next[k] = asg_valid_reg[k];
            asg_srv_next[k]   = asg_srv_reg[k];
            if (clear_all) begin
                asg_valid_next[k] = 1'b0;
            end
            if (unasg_en && asg_valid_reg[k] && (asg_srv_reg[k] == tgt_reg)) begin
                asg_valid_next[k] = 1'b0;
            end
            if (claim_en && !asg_valid_next[k] && ({1'b0, claim_srv} < eff_srv)
                && (4'(k) < eff_typ) && compat_reg[{claim_srv, 3'(k)}]) begin
                asg_valid_next[k] = 1'b1;
                asg_srv_next[k]   = claim_srv;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            ring_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= ring_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            compat_reg <= '0;
            tcnt_reg   <= '0;
            ntypes_reg <= '0;
            nsrv_reg   <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_COMPAT:      compat_reg <= cfg_wdata;
                CFG_TOKEN_CNTS:  tcnt_reg   <= cfg_wdata[31:0];
                CFG_NUM_TYPES:   ntypes_reg <= cfg_wdata[3:0];
                CFG_NUM_SERVERS: nsrv_reg   <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            tail_reg    <= '0;
            pend_reg    <= 1'b0;
            hit_reg     <= 1'b0;
            rs_srv_reg  <= '0;
            rs_left_reg <= '0;
            for (int k = 0; k < NUM_TYPES; k++) begin
                asg_valid_reg[k] <= 1'b0;
            end
            for (int i = 0; i < NUM_SERVERS; i++) begin
                jobs_reg[i] <= 4'd0;
            end
        end else begin
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            pend_reg    <= pend_next;
            hit_reg     <= hit_next;
            rs_srv_reg  <= rs_srv_next;
            rs_left_reg <= rs_left_next;
            asg_valid_reg <= asg_valid_next;
            jobs_reg      <= jobs_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg          <= op_next;
        type_reg        <= type_next;
        srv_reg         <= srv_next;
        asg_srv_reg     <= asg_srv_next;
        iss_reg         <= iss_next;
        pend_addr_reg   <= pend_addr_next;
        hit_addr_reg    <= hit_addr_next;
        carry_reg       <= carry_next;
        tgt_reg         <= tgt_next;
        shq_reg         <= shq_next;
        shfirst_reg     <= shfirst_next;
        rs_cur_reg      <= rs_cur_next;
        res_outcome_reg <= res_outcome_next;
        res_chosen_reg  <= res_chosen_next;
        res_jv_reg      <= res_jv_next;
    end

    assign cnt_wide = 9'(ring_cnt);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            m_outcome        <= res_outcome_reg;
            m_chosen_server  <= res_chosen_reg;
            m_jobs_at_server <= res_jv_reg ? jobs_reg[res_chosen_reg[SW-1:0]] : 4'd0;
            m_tokens_queued  <= (cnt_wide > 9'd127) ? 7'd127 : cnt_wide[6:0];
        end
    end

endmodule

/* rtl/tqjd_checker.sv */
// ----------------------------------------------------------------------------
// tqjd_checker
// Port-level checks on the dispatcher, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "token_queue_job_dispatcher_unit_macros.svh"

module tqjd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [2:0] m_outcome,
    input logic [2:0] m_chosen_server,
    input logic [3:0] m_jobs_at_server
);
    import tqjd_pkg::*;

    // A waiting result holds.
    `TQJD_ASSERT_NXT(a_result_holds, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_outcome) && $stable(m_chosen_server))

    // Only one item is in work at a time.
    `TQJD_ASSERT_NXT(a_one_in_work, aclk, aresetn, s_valid && s_ready, !s_ready)

    // An assigned job leaves its server with at least one job.
    `TQJD_ASSERT_IMP(a_assigned_busy, aclk, aresetn, m_valid && (m_outcome == OUT_ASSIGNED), m_jobs_at_server != 4'd0)

    // Lost jobs and restarts name no server.
    `TQJD_ASSERT_IMP(a_no_server, aclk, aresetn, m_valid && ((m_outcome == OUT_LOST) || (m_outcome == OUT_RESTARTED)), (m_chosen_server == 3'd0) && (m_jobs_at_server == 4'd0))

endmodule

bind token_queue_job_dispatcher_unit tqjd_checker u_tqjd_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_outcome        (m_outcome),
    .m_chosen_server  (m_chosen_server),
    .m_jobs_at_server (m_jobs_at_server)
);
